// ===== design/svpwm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, fixed-point constants, sector codes and stage payload types
// for the space vector PWM duty generator.
// ---------------------------------------------------------------------------
package svpwm_pkg;

  // field and datapath widths
  localparam int PH_W   = 16;   // phase references and compare values, Q2.13
  localparam int AB_W   = 34;   // alpha and beta, Q.29
  localparam int WIDE_W = 56;   // sector tests and times, Q.45 / Q.47
  localparam int SEC_W  = 3;

  typedef logic signed [PH_W-1:0]   phase_t;
  typedef logic signed [AB_W-1:0]   ab_word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [SEC_W-1:0]         sector_t;

  // sector numbers
  localparam sector_t SEC_1 = 3'd1;
  localparam sector_t SEC_2 = 3'd2;
  localparam sector_t SEC_3 = 3'd3;
  localparam sector_t SEC_4 = 3'd4;
  localparam sector_t SEC_5 = 3'd5;
  localparam sector_t SEC_6 = 3'd6;

  // one in Q.47
  localparam wide_t ONE_Q47 = wide_t'(1) <<< 47;

  // three phase references
  typedef struct packed {
    phase_t phase_c;
    phase_t phase_b;
    phase_t phase_a;
  } phase_set_t;

  // stationary frame vector
  typedef struct packed {
    ab_word_t alpha;
    ab_word_t beta;
  } ab_t;

  // sector, active times and half zero time
  typedef struct packed {
    sector_t sector;
    wide_t   t1;
    wide_t   t2;
    wide_t   odd1;
  } dwell_t;

  // compare values and sector
  typedef struct packed {
    sector_t sector;
    phase_t  duty_c;
    phase_t  duty_b;
    phase_t  duty_a;
  } duty_set_t;

endpackage

// ===== design/svpwm_clarke.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_clarke
// Two-stage Clarke transform with 2/3 scaling: three constant products in
// the first stage, the alpha difference in the second.
// ---------------------------------------------------------------------------
module svpwm_clarke (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s_valid,
  output logic                   s_ready,
  input  svpwm_pkg::phase_set_t  s_data,
  output logic                   m_valid,
  input  logic                   m_ready,
  output svpwm_pkg::ab_t         m_data
);
  import svpwm_pkg::*;

  localparam ab_word_t K_TWO_THIRDS = 34'sd43691;
  localparam ab_word_t K_ONE_THIRD  = 34'sd21845;
  localparam ab_word_t K_INV_SQRT3  = 34'sd37837;

  logic     v1_r;
  logic     v2_r;
  logic     en1;
  logic     en2;
  ab_word_t a_w;
  ab_word_t bc_sum;
  ab_word_t bc_diff;
  ab_word_t m_a_nxt;
  ab_word_t m_bc_nxt;
  ab_word_t beta_nxt;
  ab_word_t m_a_r;
  ab_word_t m_bc_r;
  ab_word_t beta1_r;
  ab_t      ab_nxt;
  ab_t      ab_r;

  // stage enables, a stage moves when empty or when the next one moves
  assign en2     = !v2_r || m_ready;
  assign en1     = !v1_r || en2;
  assign s_ready = en1;

  // stage 1: constant products
  always_comb begin
    a_w      = AB_W'(s_data.phase_a);
    bc_sum   = AB_W'(s_data.phase_b) + AB_W'(s_data.phase_c);
    bc_diff  = AB_W'(s_data.phase_b) - AB_W'(s_data.phase_c);
    m_a_nxt  = a_w * K_TWO_THIRDS;
    m_bc_nxt = bc_sum * K_ONE_THIRD;
    beta_nxt = bc_diff * K_INV_SQRT3;
  end

  // stage 2: alpha difference
  always_comb begin
    ab_nxt.alpha = m_a_r - m_bc_r;
    ab_nxt.beta  = beta1_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= s_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1 && s_valid) begin
      m_a_r   <= m_a_nxt;
      m_bc_r  <= m_bc_nxt;
      beta1_r <= beta_nxt;
    end
    if (en2 && v1_r) begin
      ab_r <= ab_nxt;
    end
  end

  assign m_valid = v2_r;
  assign m_data  = ab_r;

endmodule

// ===== design/svpwm_timing.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_timing
// Four-stage sector and dwell time unit: scaled products, sector sign
// tests, per-sector active times, then the half zero time.
// ---------------------------------------------------------------------------
module svpwm_timing (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  output logic              s_ready,
  input  svpwm_pkg::ab_t    s_data,
  output logic              m_valid,
  input  logic              m_ready,
  output svpwm_pkg::dwell_t m_data
);
  import svpwm_pkg::*;

  localparam wide_t K_SQRT3 = 56'sd113508;

  // sign test codes: bit 2 beta not positive, bit 1 and bit 0 the sloped tests
  localparam logic [2:0] TST_SEC2 = 3'd0;
  localparam logic [2:0] TST_SEC3 = 3'd1;
  localparam logic [2:0] TST_SEC1 = 3'd2;
  localparam logic [2:0] TST_SEC4 = 3'd5;
  localparam logic [2:0] TST_SEC5 = 3'd7;

  function automatic sector_t sector_of(input logic [2:0] code);
    sector_t s;
    case (code)
      TST_SEC1: s = SEC_1;
      TST_SEC2: s = SEC_2;
      TST_SEC3: s = SEC_3;
      TST_SEC4: s = SEC_4;
      TST_SEC5: s = SEC_5;
      default:  s = SEC_6;   // sector 6 and the boundary codes
    endcase
    return s;
  endfunction

  logic       v1_r, v2_r, v3_r, v4_r;
  logic       en1, en2, en3, en4;
  wide_t      beta_w;
  wide_t      al45_nxt;
  wide_t      al45_r, beta45_r;
  logic       bpos_r;
  logic [2:0] code;
  wide_t      d_minus, d_plus;
  sector_t    sector2_nxt, sector2_r;
  wide_t      al45_2_r, beta45_2_r;
  wide_t      al1, be1, bef;
  wide_t      t1_nxt, t2_nxt;
  sector_t    sector3_r;
  wide_t      t1_3_r, t2_3_r;
  wide_t      odd1_nxt;
  dwell_t     dw_r;

  // stage enables
  assign en4     = !v4_r || m_ready;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign s_ready = en1;

  // stage 1: alpha times sqrt(3), beta into Q.45
  always_comb begin
    beta_w   = WIDE_W'(s_data.beta);
    al45_nxt = WIDE_W'(s_data.alpha) * K_SQRT3;
  end

  // stage 2: sign tests and sector
  always_comb begin
    d_minus     = beta45_r - al45_r;
    d_plus      = beta45_r + al45_r;
    code[2]     = !bpos_r;
    code[1]     = !(d_minus > 0);
    code[0]     = !(d_plus > 0);
    sector2_nxt = sector_of(code);
  end

  // stage 3: active times per sector
  always_comb begin
    al1 = al45_2_r <<< 1;
    be1 = beta45_2_r <<< 1;
    bef = beta45_2_r <<< 2;
    case (sector2_r)
      SEC_1: begin
        t1_nxt = al1 - be1;
        t2_nxt = bef;
      end
      SEC_2: begin
        t1_nxt = al1 + be1;
        t2_nxt = be1 - al1;
      end
      SEC_3: begin
        t1_nxt = bef;
        t2_nxt = -al1 - be1;
      end
      SEC_4: begin
        t1_nxt = be1 - al1;
        t2_nxt = -bef;
      end
      SEC_5: begin
        t1_nxt = -al1 - be1;
        t2_nxt = al1 - be1;
      end
      default: begin   // sector 6
        t1_nxt = -bef;
        t2_nxt = al1 + be1;
      end
    endcase
  end

  // stage 4: half zero time, always even so the shift is exact
  assign odd1_nxt = (ONE_Q47 - t1_3_r - t2_3_r) >>> 1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= s_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1 && s_valid) begin
      al45_r   <= al45_nxt;
      beta45_r <= beta_w <<< 16;
      bpos_r   <= s_data.beta > 0;
    end
    if (en2 && v1_r) begin
      sector2_r  <= sector2_nxt;
      al45_2_r   <= al45_r;
      beta45_2_r <= beta45_r;
    end
    if (en3 && v2_r) begin
      sector3_r <= sector2_r;
      t1_3_r    <= t1_nxt;
      t2_3_r    <= t2_nxt;
    end
    if (en4 && v3_r) begin
      dw_r.sector <= sector3_r;
      dw_r.t1     <= t1_3_r;
      dw_r.t2     <= t2_3_r;
      dw_r.odd1   <= odd1_nxt;
    end
  end

  assign m_valid = v4_r;
  assign m_data  = dw_r;

`ifndef NO_ASSERTIONS
  // the three segment times add back up to one period
  a_period_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (WIDE_W'(dw_r.t1 + dw_r.t2 + (dw_r.odd1 <<< 1)) == ONE_Q47))
    else $error("segment times do not sum to one period");

  // a positive beta never lands in the lower half-plane sectors
  a_upper_half: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && en2 && bpos_r) |=>
      (sector2_r == SEC_1 || sector2_r == SEC_2 || sector2_r == SEC_3))
    else $error("positive beta gave a lower sector");
`endif

endmodule

// ===== design/svpwm_compare.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_compare
// Two-stage compare value unit: seven-segment assignment of the switching
// instants to phases, then rounding to Q2.13 with saturation.
// ---------------------------------------------------------------------------
module svpwm_compare (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  svpwm_pkg::dwell_t    s_data,
  output logic                 m_valid,
  input  logic                 m_ready,
  output svpwm_pkg::duty_set_t m_data
);
  import svpwm_pkg::*;

  localparam wide_t HALF_LSB = wide_t'(1) <<< 33;
  localparam wide_t Q13_MAX  = 56'sd32767;
  localparam wide_t Q13_MIN  = -56'sd32768;

  // Q.47 to Q.13, ties toward plus infinity, then saturate
  function automatic phase_t to_q13(input wide_t v);
    wide_t  r;
    phase_t q;
    r = (v + HALF_LSB) >>> 34;
    if (r > Q13_MAX) begin
      q = 16'sh7fff;
    end else if (r < Q13_MIN) begin
      q = -16'sh8000;
    end else begin
      q = r[PH_W-1:0];
    end
    return q;
  endfunction

  logic      v1_r, v2_r;
  logic      en1, en2;
  wide_t     odd1, odd2, odd3, even1;
  wide_t     va_nxt, vb_nxt, vc_nxt;
  wide_t     va_r, vb_r, vc_r;
  sector_t   sector1_r;
  duty_set_t duty_r;

  assign en2     = !v2_r || m_ready;
  assign en1     = !v1_r || en2;
  assign s_ready = en1;

  // stage 1: switching instants and phase assignment
  always_comb begin
    odd1  = s_data.odd1;
    odd2  = s_data.t1 + odd1;
    odd3  = s_data.t1 + s_data.t2 + odd1;
    even1 = s_data.t2 + odd1;
    case (s_data.sector)
      SEC_1: begin
        va_nxt = odd1;
        vb_nxt = odd2;
        vc_nxt = odd3;
      end
      SEC_2: begin
        va_nxt = even1;
        vb_nxt = odd1;
        vc_nxt = odd3;
      end
      SEC_3: begin
        va_nxt = odd3;
        vb_nxt = odd1;
        vc_nxt = odd2;
      end
      SEC_4: begin
        va_nxt = odd3;
        vb_nxt = even1;
        vc_nxt = odd1;
      end
      SEC_5: begin
        va_nxt = odd2;
        vb_nxt = odd3;
        vc_nxt = odd1;
      end
      default: begin   // sector 6
        va_nxt = odd1;
        vb_nxt = odd3;
        vc_nxt = even1;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= s_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  // payload, stage 2 rounds and saturates into the output register
  always_ff @(posedge clk) begin
    if (en1 && s_valid) begin
      va_r      <= va_nxt;
      vb_r      <= vb_nxt;
      vc_r      <= vc_nxt;
      sector1_r <= s_data.sector;
    end
    if (en2 && v1_r) begin
      duty_r.duty_a <= to_q13(va_r);
      duty_r.duty_b <= to_q13(vb_r);
      duty_r.duty_c <= to_q13(vc_r);
      duty_r.sector <= sector1_r;
    end
  end

  assign m_valid = v2_r;
  assign m_data  = duty_r;

endmodule

// ===== design/svpwm_duty_generator.sv =====
`timescale 1ns / 1ps
// Pipeline: 2 Clarke, 4 timing and 2 compare stages from an accepted request
//   to out_tvalid; a result holds in them while the result side stalls.
// Throughput: one request per cycle; each stage loads when empty or draining,
//   so bubbles close up and in_tready stays high while out_tready is high.
// Reset: synchronous rst_n clears the stage valid bits only; no other state.
// ---------------------------------------------------------------------------
// svpwm_duty_generator
// Seven-segment space vector PWM: phase references in, three compare values
// and the sector out, one result per request.
// ---------------------------------------------------------------------------
module svpwm_duty_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // phase_a[15:0], phase_b[31:16], phase_c[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // duty_a[15:0], duty_b[31:16], duty_c[47:32],
                                  // sector[50:48], zero[55:51]
);
  import svpwm_pkg::*;

  phase_set_t ph;
  logic       ab_valid, ab_ready;
  ab_t        ab;
  logic       dw_valid, dw_ready;
  dwell_t     dw;
  duty_set_t  duty;

  // unpack the request
  always_comb begin
    ph.phase_a = in_tdata[15:0];
    ph.phase_b = in_tdata[31:16];
    ph.phase_c = in_tdata[47:32];
  end

  svpwm_clarke u_clarke (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (ph),
    .m_valid (ab_valid),
    .m_ready (ab_ready),
    .m_data  (ab)
  );

  svpwm_timing u_timing (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (ab_valid),
    .s_ready (ab_ready),
    .s_data  (ab),
    .m_valid (dw_valid),
    .m_ready (dw_ready),
    .m_data  (dw)
  );

  svpwm_compare u_compare (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (dw_valid),
    .s_ready (dw_ready),
    .s_data  (dw),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (duty)
  );

  // pack the result
  assign out_tdata = {5'b0, duty.sector, duty.duty_c, duty.duty_b, duty.duty_a};

`ifndef NO_ASSERTIONS
  // reported sector is always one of the six
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[50:48] == SEC_1 || out_tdata[50:48] == SEC_2 ||
                    out_tdata[50:48] == SEC_3 || out_tdata[50:48] == SEC_4 ||
                    out_tdata[50:48] == SEC_5 || out_tdata[50:48] == SEC_6))
    else $error("sector out of range");

  // a draining output never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-segment SVPWM duty generator. A directed
// set of phase references (zero vector, rail values, one vector per sector,
// sector boundaries, bit patterns) is followed by random balanced and
// unbalanced three-phase requests. Every request is predicted in 64-bit
// integer arithmetic and each result is compared field by field, in order,
// while both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
  import svpwm_pkg::*;

  // fixed-point coefficients, Q.16
  localparam longint TWO_THIRDS_Q16 = 43691;
  localparam longint ONE_THIRD_Q16  = 21845;
  localparam longint INV_SQRT3_Q16  = 37837;
  localparam longint SQRT3_Q16      = 113508;
  localparam longint HALF_SQRT3_Q16 = 56754;

  localparam int RANDOM_ITEMS  = 1870;
  localparam int HOLD_ITEMS    = 60;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PRINT_LIMIT   = 40;

  // expected duty results and their checking
  class duty_scoreboard;
    duty_set_t expected_duty[$];
    int        mismatches;
    int        results_seen;
    int        requests_seen;
    int        clipped_values;
    int        sector_hits [SEC_1:SEC_6];

    function new();
      mismatches     = 0;
      results_seen   = 0;
      requests_seen  = 0;
      clipped_values = 0;
      foreach (sector_hits[s]) sector_hits[s] = 0;
    endfunction

    function int pending();
      return expected_duty.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("mismatch: %s", msg);
    endtask

    // Q.47 to Q.13, round half up, then clip to 16 bits
    function phase_t round_to_q13(longint v);
      longint r;
      r = (v + (longint'(1) <<< 33)) >>> 34;
      if (r > 32767) begin
        r = 32767;
        clipped_values++;
      end else if (r < -32768) begin
        r = -32768;
        clipped_values++;
      end
      return phase_t'(r);
    endfunction

    // clarke transform, sector search, dwell times, saddle placement
    function duty_set_t predict_duty(phase_set_t ph);
      longint    a, b, c, alpha, beta, beta45, al45;
      longint    al1, be1, bef, t1, t2, t0, odd1, odd2, odd3, even1;
      longint    va, vb, vc;
      bit        beta_pos, minus_pos, plus_pos;
      sector_t   sec;
      duty_set_t d;
      a = longint'(ph.phase_a);
      b = longint'(ph.phase_b);
      c = longint'(ph.phase_c);
      alpha = TWO_THIRDS_Q16 * a - ONE_THIRD_Q16 * b - ONE_THIRD_Q16 * c;
      beta  = INV_SQRT3_Q16 * (b - c);

      // three sign tests in Q.45
      beta45    = beta * 65536;
      al45      = alpha * SQRT3_Q16;
      beta_pos  = beta > 0;
      minus_pos = (beta45 - al45) > 0;
      plus_pos  = (beta45 + al45) > 0;
      if (beta_pos && minus_pos && plus_pos)         sec = SEC_2;
      else if (beta_pos && minus_pos)                sec = SEC_3;
      else if (beta_pos && plus_pos)                 sec = SEC_1;
      else if (!beta_pos && minus_pos && !plus_pos)  sec = SEC_4;
      else if (!beta_pos && !minus_pos && !plus_pos) sec = SEC_5;
      else                                           sec = SEC_6; // incl. degenerate codes

      // active times in Q.47
      al1 = alpha * HALF_SQRT3_Q16 * 4;
      be1 = beta * (longint'(1) << 17);
      bef = beta * (longint'(1) << 18);
      case (sec)
        SEC_1:   begin t1 = al1 - be1;  t2 = bef;        end
        SEC_2:   begin t1 = al1 + be1;  t2 = -al1 + be1; end
        SEC_3:   begin t1 = bef;        t2 = -al1 - be1; end
        SEC_4:   begin t1 = -al1 + be1; t2 = -bef;       end
        SEC_5:   begin t1 = -al1 - be1; t2 = al1 - be1;  end
        default: begin t1 = -bef;       t2 = al1 + be1;  end
      endcase
      t0    = longint'(ONE_Q47) - t1 - t2;
      odd1  = t0 / 2;
      odd2  = t1 + odd1;
      odd3  = t1 + t2 + odd1;
      even1 = t2 + odd1;

      // compare values per phase
      case (sec)
        SEC_1:   begin va = odd1;  vb = odd2;  vc = odd3;  end
        SEC_2:   begin va = even1; vb = odd1;  vc = odd3;  end
        SEC_3:   begin vb = odd1;  vc = odd2;  va = odd3;  end
        SEC_4:   begin vb = even1; vc = odd1;  va = odd3;  end
        SEC_5:   begin vc = odd1;  va = odd2;  vb = odd3;  end
        default: begin vc = even1; va = odd1;  vb = odd3;  end
      endcase
      d.duty_a = round_to_q13(va);
      d.duty_b = round_to_q13(vb);
      d.duty_c = round_to_q13(vc);
      d.sector = sec;
      return d;
    endfunction

    function void note_request(phase_set_t ph);
      duty_set_t d;
      d = predict_duty(ph);
      requests_seen++;
      sector_hits[d.sector]++;
      expected_duty.push_back(d);
    endfunction

    task check_result(logic [55:0] word);
      duty_set_t got, want;
      got = duty_set_t'(word[50:0]);
      results_seen++;
      if (expected_duty.size() == 0) begin
        report($sformatf("result %0d arrived with no request waiting", results_seen));
        return;
      end
      want = expected_duty.pop_front();
      if (got.duty_a !== want.duty_a)
        report($sformatf("result %0d duty_a got %0d want %0d",
                         results_seen, got.duty_a, want.duty_a));
      if (got.duty_b !== want.duty_b)
        report($sformatf("result %0d duty_b got %0d want %0d",
                         results_seen, got.duty_b, want.duty_b));
      if (got.duty_c !== want.duty_c)
        report($sformatf("result %0d duty_c got %0d want %0d",
                         results_seen, got.duty_c, want.duty_c));
      if (got.sector !== want.sector)
        report($sformatf("result %0d sector got %0d want %0d",
                         results_seen, got.sector, want.sector));
      if (word[55:51] !== '0)
        report($sformatf("result %0d pad bits got %b", results_seen, word[55:51]));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  duty_scoreboard duty_sb = new();
  bit             sender_gaps   = 1'b1;
  bit             long_hold_req = 1'b0;

  svpwm_duty_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle length: mostly short, now and then long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic phase_set_t make_req(int a, int b, int c);
    phase_set_t p;
    p.phase_a = phase_t'(a);
    p.phase_b = phase_t'(b);
    p.phase_c = phase_t'(c);
    return p;
  endfunction

  // mostly balanced three-phase sets, some with b = c, some raw noise
  function automatic phase_set_t random_request();
    int amp, a, b, c, pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return make_req($urandom, $urandom, $urandom);
    amp = ($urandom_range(0, 4) == 0) ? 32767 : $urandom_range(1, 12000);
    a = int'($urandom_range(0, 2 * amp)) - amp;
    b = int'($urandom_range(0, 2 * amp)) - amp;
    if (pick < 32) c = b;
    else c = -(a + b);
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return make_req(a, b, c);
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_request(input phase_set_t p);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (in_tready !== 1'b1);
    duty_sb.note_request(p);
    gap = (sender_gaps && $urandom_range(0, 99) < 35) ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: check, then choose the next ready level
  initial begin : result_sink
    int hold, mode_left;
    bit stalls_on;
    hold      = 0;
    mode_left = 0;
    stalls_on = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) duty_sb.check_result(out_tdata);
      if (mode_left == 0) begin
        stalls_on = $urandom_range(0, 3) != 0;
        mode_left = $urandom_range(100, 400);
      end else begin
        mode_left--;
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
        hold = pick_idle_len() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // give up when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero vector, rails, one vector per sector, boundaries, patterns
    send_request(make_req(0, 0, 0));
    send_request(make_req(32767, 32767, 32767));
    send_request(make_req(-32768, -32768, -32768));
    send_request(make_req(32767, -32768, -32768));
    send_request(make_req(-32768, 32767, 32767));
    send_request(make_req(-32768, 32767, -32768));
    send_request(make_req(32767, 32767, -32768));
    send_request(make_req(4096, 0, -4096));
    send_request(make_req(0, 4096, -4096));
    send_request(make_req(-4096, 4096, 0));
    send_request(make_req(-4096, 0, 4096));
    send_request(make_req(0, -4096, 4096));
    send_request(make_req(4096, -4096, 0));
    // beta exactly zero, both signs of alpha
    send_request(make_req(8192, -4096, -4096));
    send_request(make_req(-8192, 4096, 4096));
    send_request(make_req(1, 0, 0));
    send_request(make_req(-1, 0, 0));
    send_request(make_req(0, 1, -1));
    send_request(make_req(21845, -21846, 0));
    send_request(make_req(-21846, 21845, -21846));

    // sender pauses until the pipeline is empty
    in_tvalid <= 1'b0;
    while (duty_sb.pending() != 0) @(posedge clk);

    // receiver holds off while requests keep coming, pipeline backs up
    sender_gaps   = 1'b0;
    long_hold_req = 1'b1;
    repeat (HOLD_ITEMS) send_request(random_request());

    // random requests, gap mode changing every couple of hundred
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) sender_gaps = $urandom_range(0, 2) != 0;
      send_request(random_request());
    end
    in_tvalid <= 1'b0;

    // drain, then allow for anything spurious behind the last result
    while (duty_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results, %0d compare values clipped",
             duty_sb.requests_seen, duty_sb.results_seen, duty_sb.clipped_values);
    $display("sector use 1..6: %0d %0d %0d %0d %0d %0d, %0d mismatches",
             duty_sb.sector_hits[SEC_1], duty_sb.sector_hits[SEC_2],
             duty_sb.sector_hits[SEC_3], duty_sb.sector_hits[SEC_4],
             duty_sb.sector_hits[SEC_5], duty_sb.sector_hits[SEC_6],
             duty_sb.mismatches);
    if (duty_sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
